### design/ppcf_pkg.sv
// Package for the ping-pong command FIFO: sizes, operation codes and the
// control struct passed from the pointer controller to the top level.
// No dependencies.
package ppcf_pkg;

    localparam int SLOTS  = 16;
    localparam int ARGS   = 4;
    localparam int BANKS  = 2;

    localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W = $clog2(BANKS * SLOTS);
    localparam int WORD_W = 32;
    localparam int TYPE_W = 8;
    localparam int SLOT_W = TYPE_W + ARGS * WORD_W;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_SWAP = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic              we;
        logic              re;
        logic              ok;
        logic              pop;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } mem_ctrl_t;

endpackage

### design/ppcf_slot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppcf_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ppcf_ptr_ctrl.sv
// Front and end pointers of both banks and the send-bank flag; decides each
// item's outcome and the slot memory access. Depends on ppcf_pkg.
module ppcf_ptr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        kind,
    output ppcf_pkg::mem_ctrl_t ctrl
);

    localparam logic [ppcf_pkg::PTR_W-1:0] LAST =
        ppcf_pkg::PTR_W'(ppcf_pkg::SLOTS - 1);
    localparam logic [ppcf_pkg::PTR_W-1:0] END_RST =
        ppcf_pkg::PTR_W'(1 % ppcf_pkg::SLOTS);
    localparam logic [ppcf_pkg::ADDR_W-1:0] BANK_OFS =
        ppcf_pkg::ADDR_W'(ppcf_pkg::SLOTS);

    logic [ppcf_pkg::PTR_W-1:0] front_reg [ppcf_pkg::BANKS];
    logic [ppcf_pkg::PTR_W-1:0] end_reg   [ppcf_pkg::BANKS];
    logic                       send_bank_reg;

    logic                       recv_bank;
    logic [ppcf_pkg::PTR_W-1:0] send_end;
    logic [ppcf_pkg::PTR_W-1:0] send_front;
    logic [ppcf_pkg::PTR_W-1:0] recv_end;
    logic [ppcf_pkg::PTR_W-1:0] recv_front;
    logic [ppcf_pkg::PTR_W-1:0] send_end_next;
    logic [ppcf_pkg::PTR_W-1:0] recv_front_next;
    logic                       full;
    logic                       empty;

    assign recv_bank       = ~send_bank_reg;
    assign send_end        = end_reg[send_bank_reg];
    assign send_front      = front_reg[send_bank_reg];
    assign recv_end        = end_reg[recv_bank];
    assign recv_front      = front_reg[recv_bank];
    assign send_end_next   = (send_end == LAST) ? '0 : send_end + 1'b1;
    assign recv_front_next = (recv_front == LAST) ? '0 : recv_front + 1'b1;
    assign full            = (send_end == send_front);
    assign empty           = (recv_front_next == recv_end);

    always_comb
    begin
        ctrl       = '0;
        ctrl.waddr = (send_bank_reg ? BANK_OFS : '0) + ppcf_pkg::ADDR_W'(send_end);
        ctrl.raddr = (recv_bank ? BANK_OFS : '0) + ppcf_pkg::ADDR_W'(recv_front_next);
        case (kind)
            ppcf_pkg::KIND_PUSH:
            begin
                ctrl.ok = ~full;
                ctrl.we = accept & ~full;
            end
            ppcf_pkg::KIND_POP:
            begin
                ctrl.ok  = ~empty;
                ctrl.pop = ~empty;
                ctrl.re  = accept & ~empty;
            end
            ppcf_pkg::KIND_SWAP:
            begin
                ctrl.ok = 1'b1;
            end
            default:
            begin
                ctrl.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < ppcf_pkg::BANKS; b++)
            begin
                front_reg[b] <= '0;
                end_reg[b]   <= END_RST;
            end
            send_bank_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (ctrl.we)
            begin
                end_reg[send_bank_reg] <= send_end_next;
            end
            if (ctrl.re)
            begin
                front_reg[recv_bank] <= recv_front_next;
            end
            if (kind == ppcf_pkg::KIND_SWAP)
            begin
                send_bank_reg <= ~send_bank_reg;
            end
        end
    end

endmodule

### design/ping_pong_command_fifo.sv
// Ping-pong command FIFO top level. Depends on ppcf_pkg, ppcf_ptr_ctrl, ppcf_slot_ram.
// An accepted item's result is registered and appears in the next cycle; pop data come from the slot RAM read.
// Throughput: one item per cycle while results are taken; the result register
// holds one item, so a stalled result blocks the next item.
// Reset: asynchronous, active low; pointers and bank flag reset, slot RAM is not cleared.
module ping_pong_command_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  cmd_type,
    input  logic [31:0] arg_a,
    input  logic [31:0] arg_b,
    input  logic [31:0] arg_c,
    input  logic [31:0] arg_d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [7:0]  out_type,
    output logic [31:0] out_a,
    output logic [31:0] out_b,
    output logic [31:0] out_c,
    output logic [31:0] out_d
);

    ppcf_pkg::mem_ctrl_t          ctrl;
    logic                         accept;
    logic                         valid_reg;
    logic                         ok_reg;
    logic                         pop_reg;
    logic [ppcf_pkg::SLOT_W-1:0]  wdata;
    logic [ppcf_pkg::SLOT_W-1:0]  rdata;
    logic [3:0][31:0]             args_in;
    logic [3:0][31:0]             args_out;

    assign in_ready = ~valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign args_in  = {arg_d, arg_c, arg_b, arg_a};

    ppcf_ptr_ctrl u_ptr (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (kind),
        .ctrl   (ctrl)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_args
        if (i < ppcf_pkg::ARGS)
        begin : g_used
            assign wdata[i*ppcf_pkg::WORD_W +: ppcf_pkg::WORD_W] = args_in[i];
            assign args_out[i] = pop_reg ? rdata[i*ppcf_pkg::WORD_W +: ppcf_pkg::WORD_W]
                                         : '0;
        end
        else
        begin : g_unused
            assign args_out[i] = '0;
        end
    end

    assign wdata[ppcf_pkg::ARGS*ppcf_pkg::WORD_W +: ppcf_pkg::TYPE_W] = cmd_type;

    ppcf_slot_ram #(
        .WIDTH (ppcf_pkg::SLOT_W),
        .DEPTH (ppcf_pkg::BANKS * ppcf_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.we),
        .waddr (ctrl.waddr),
        .wdata (wdata),
        .re    (ctrl.re),
        .raddr (ctrl.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg    <= 1'b0;
            pop_reg   <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
            ok_reg    <= in_valid & ctrl.ok;
            pop_reg   <= in_valid & ctrl.pop;
        end
    end

    assign out_valid = valid_reg;
    assign ok        = ok_reg;
    assign out_type  = pop_reg ? rdata[ppcf_pkg::ARGS*ppcf_pkg::WORD_W +: ppcf_pkg::TYPE_W]
                               : '0;
    assign out_a     = args_out[0];
    assign out_b     = args_out[1];
    assign out_c     = args_out[2];
    assign out_d     = args_out[3];

endmodule

### design/ppcf_checker.sv
// Port-level checks for the ping-pong command FIFO, bound to the top level.
// Depends on ppcf_pkg and ping_pong_command_fifo.
module ppcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic        ok,
    input logic [7:0]  out_type,
    input logic [31:0] out_a,
    input logic [31:0] out_b,
    input logic [31:0] out_c,
    input logic [31:0] out_d
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(out_type)
                                    && $stable(out_a))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> out_type == 8'd0 && out_a == 32'd0 && out_b == 32'd0
                             && out_c == 32'd0 && out_d == 32'd0)
        else $error("failed item carries data");

    a_swap_ok: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == ppcf_pkg::KIND_SWAP |=> ok && out_type == 8'd0)
        else $error("swap result wrong");

    a_none_fails: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == ppcf_pkg::KIND_NONE |=> !ok)
        else $error("unused kind reported success");

endmodule

bind ping_pong_command_fifo ppcf_checker u_ppcf_checker (.*);

### test/tb_top.sv
// Testbench for ping_pong_command_fifo: random push, pop, swap and unused-kind items with
// random gaps on both handshakes, checked against a bank-level model.
// Depends on ppcf_pkg and the design files only.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 950;

    typedef struct packed {
        logic             ok;
        logic [7:0]       typ;
        logic [3:0][31:0] words;
    } cmd_result_t;

    class fifo_model;
        logic [7:0]  type_mem [ppcf_pkg::BANKS][ppcf_pkg::SLOTS];
        logic [31:0] word_mem [ppcf_pkg::BANKS][ppcf_pkg::SLOTS][4];
        int unsigned head [ppcf_pkg::BANKS];
        int unsigned tail [ppcf_pkg::BANKS];
        bit          send_sel;
        cmd_result_t due_results [$];
        int          faults;
        int          push_done, push_full, pop_done, pop_empty, swaps, no_ops;

        function new();
            for (int b = 0; b < ppcf_pkg::BANKS; b++)
            begin
                head[b] = 0;
                tail[b] = 1 % ppcf_pkg::SLOTS;
            end
            send_sel  = 1'b0;
            faults    = 0;
            push_done = 0;
            push_full = 0;
            pop_done  = 0;
            pop_empty = 0;
            swaps     = 0;
            no_ops    = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_item(logic [1:0] k, logic [7:0] t, logic [3:0][31:0] w);
            cmd_result_t r;
            int unsigned b;
            r = '0;
            case (k)
                ppcf_pkg::KIND_PUSH:
                begin
                    b = send_sel ? 1 : 0;
                    if (tail[b] == head[b])
                        push_full++;
                    else
                    begin
                        type_mem[b][tail[b]] = t;
                        for (int i = 0; i < ppcf_pkg::ARGS && i < 4; i++)
                            word_mem[b][tail[b]][i] = w[i];
                        tail[b] = (tail[b] + 1) % ppcf_pkg::SLOTS;
                        r.ok = 1'b1;
                        push_done++;
                    end
                end
                ppcf_pkg::KIND_POP:
                begin
                    b = send_sel ? 0 : 1;
                    if ((head[b] + 1) % ppcf_pkg::SLOTS == tail[b])
                        pop_empty++;
                    else
                    begin
                        head[b] = (head[b] + 1) % ppcf_pkg::SLOTS;
                        r.ok  = 1'b1;
                        r.typ = type_mem[b][head[b]];
                        for (int i = 0; i < ppcf_pkg::ARGS && i < 4; i++)
                            r.words[i] = word_mem[b][head[b]][i];
                        pop_done++;
                    end
                end
                ppcf_pkg::KIND_SWAP:
                begin
                    send_sel = !send_sel;
                    r.ok = 1'b1;
                    swaps++;
                end
                default:
                    no_ops++;
            endcase
            due_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                faults++;
            end
        endfunction

        function void check_item(cmd_result_t got);
            cmd_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with no item outstanding");
                faults++;
                return;
            end
            want = due_results.pop_front();
            check_field("ok", 32'(want.ok), 32'(got.ok));
            check_field("out_type", 32'(want.typ), 32'(got.typ));
            check_field("out_a", want.words[0], got.words[0]);
            check_field("out_b", want.words[1], got.words[1]);
            check_field("out_c", want.words[2], got.words[2]);
            check_field("out_d", want.words[3], got.words[3]);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  kind      = ppcf_pkg::KIND_NONE;
    logic [7:0]  cmd_type  = '0;
    logic [31:0] arg_a     = '0;
    logic [31:0] arg_b     = '0;
    logic [31:0] arg_c     = '0;
    logic [31:0] arg_d     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic [7:0]  out_type;
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;

    fifo_model   sb;
    bit          calm = 1'b0;
    int          sent = 0;
    int          quiet_cycles = 0;
    int          stall;

    ping_pong_command_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .cmd_type  (cmd_type),
        .arg_a     (arg_a),
        .arg_b     (arg_b),
        .arg_c     (arg_c),
        .arg_d     (arg_d),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .out_type  (out_type),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .out_d     (out_d)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0][31:0] pick_words();
        logic [3:0][31:0] w;
        for (int i = 0; i < 4; i++)
            w[i] = pick_word();
        return w;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [7:0] t,
                             input logic [3:0][31:0] w);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        cmd_type <= t;
        arg_a    <= w[0];
        arg_b    <= w[1];
        arg_c    <= w[2];
        arg_d    <= w[3];
        do @(posedge clk); while (in_ready !== 1'b1);
        sent++;
    endtask

    task automatic send_random(input logic [1:0] k);
        send_item(k, 8'($urandom_range(0, 255)), pick_words());
    endtask

    // Check results before noting inputs: a result never belongs to the item taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_item('{ok: ok, typ: out_type, words: {out_d, out_c, out_b, out_a}});
            if (in_valid && in_ready)
                sb.note_item(kind, cmd_type, {arg_d, arg_c, arg_b, arg_a});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL ping_pong_command_fifo");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        int phase;
        int n;
        int r;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, no-op, field extremes, swap and drain past empty.
        send_random(ppcf_pkg::KIND_POP);
        send_item(ppcf_pkg::KIND_NONE, 8'hFF, {4{32'hFFFF_FFFF}});
        send_item(ppcf_pkg::KIND_PUSH, 8'h00, {4{32'h0000_0000}});
        send_item(ppcf_pkg::KIND_PUSH, 8'hFF, {4{32'hFFFF_FFFF}});
        send_item(ppcf_pkg::KIND_PUSH, 8'hA5, {32'h5555_5555, 32'hAAAA_AAAA,
                                               32'h0F0F_0F0F, 32'hF0F0_F0F0});
        send_item(ppcf_pkg::KIND_PUSH, 8'h5A, {32'hAAAA_AAAA, 32'h5555_5555,
                                               32'hF0F0_F0F0, 32'h0F0F_0F0F});
        send_random(ppcf_pkg::KIND_SWAP);
        repeat (5) send_random(ppcf_pkg::KIND_POP);
        send_random(ppcf_pkg::KIND_PUSH);
        send_random(ppcf_pkg::KIND_SWAP);
        send_random(ppcf_pkg::KIND_POP);
        send_random(ppcf_pkg::KIND_POP);
        send_random(ppcf_pkg::KIND_NONE);

        // Random: fill and drain bursts with swaps, mixed with noise.
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                calm = !calm;
            phase = $urandom_range(0, 9);
            if (phase <= 2)
            begin
                n = $urandom_range(1, 18);
                repeat (n) send_random(ppcf_pkg::KIND_PUSH);
            end
            else if (phase <= 5)
            begin
                n = $urandom_range(1, 18);
                repeat (n) send_random(ppcf_pkg::KIND_POP);
            end
            else if (phase == 6)
                send_random(ppcf_pkg::KIND_SWAP);
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    r = $urandom_range(0, 9);
                    if (r <= 3)
                        send_random(ppcf_pkg::KIND_PUSH);
                    else if (r <= 7)
                        send_random(ppcf_pkg::KIND_POP);
                    else if (r == 8)
                        send_random(ppcf_pkg::KIND_SWAP);
                    else
                        send_random(ppcf_pkg::KIND_NONE);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d items: %0d pushes stored, %0d refused on a full bank, %0d swaps,",
                 sent, sb.push_done, sb.push_full, sb.swaps);
        $display("%0d pops returned, %0d refused on an empty bank, %0d unused operations.",
                 sb.pop_done, sb.pop_empty, sb.no_ops);
        if (sb.faults == 0)
            $display("PASS ping_pong_command_fifo");
        else
            $display("FAIL ping_pong_command_fifo");
        $finish;
    end

endmodule
